// ===== hdl/bbr_pkg.sv =====
// Shared constants, types and helpers of the 3x3 RGB box blur.
`timescale 1ns / 1ps
package bbr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int CFG_W      = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SLOT_W     = 2;
  localparam int ADDR_W     = $clog2(3 * MAX_WIDTH);
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int CSUM_W     = CH_W + 2;
  localparam int WSUM_W     = CH_W + 4;
  // floor(x / 9) == (x * RECIP9) >> RECIP_SH for every window sum of 8-bit channels
  localparam int RECIP9     = 7282;
  localparam int RECIP_SH   = 16;
  localparam int JQ_DEPTH   = 4;
  localparam int RQ_DEPTH   = 4;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } bbr_reg_e;

  // One unit of work for the back end: a pixel write plus window step, or a drain read.
  typedef struct packed {
    logic              drain;
    logic [PIX_W-1:0]  pix;
    logic [SLOT_W-1:0] slot_wr;
    logic [SLOT_W-1:0] slot_a;
    logic [SLOT_W-1:0] slot_b;
    logic [COL_W-1:0]  col;
    logic              emit1;
    logic              emit2;
    logic              interior;
    logic              last;
  } bbr_job_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } bbr_res_t;

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(2)) ? SLOT_W'(0) : s + SLOT_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(0)) ? SLOT_W'(2) : s - SLOT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [COL_W-1:0]  c);
    return ADDR_W'(s) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
  endfunction

endpackage

// ===== hdl/bbr_stream_if.sv =====
// Valid/ready stream interfaces for input pixels and output words.
`timescale 1ns / 1ps
interface bbr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, action, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface bbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// ===== hdl/bbr_front.sv =====
// Front end: accepts words, tracks frame position and turns each word it does not ignore into a back-end job.
`timescale 1ns / 1ps
module bbr_front
  import bbr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic [CFG_W-1:0] width_i,
  input  logic [CFG_W-1:0] height_i,
  bbr_in_if.sink           in_i,
  input  logic             jq_full_i,
  output logic             jq_push_o,
  output bbr_job_t         jq_job_o
);

  logic [COL_W-1:0]  w_last;
  logic [ROW_W-1:0]  h_last;
  logic              accept;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              draining_q, draining_d;
  logic [COL_W-1:0]  drain_col_q, drain_col_d;
  logic [SLOT_W-1:0] drain_slot_q, drain_slot_d;

  // clamp sizes to 3..max, kept as last index
  always_comb begin
    if (width_i < CFG_W'(3)) begin
      w_last = COL_W'(2);
    end else if (int'(width_i) > MAX_WIDTH) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(width_i - CFG_W'(1));
    end
    if (height_i < CFG_W'(3)) begin
      h_last = ROW_W'(2);
    end else if (int'(height_i) > MAX_HEIGHT) begin
      h_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(height_i - CFG_W'(1));
    end
  end

  assign in_i.ready = !jq_full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    row_d        = row_q;
    col_d        = col_q;
    slot_d       = slot_q;
    draining_d   = draining_q;
    drain_col_d  = drain_col_q;
    drain_slot_d = drain_slot_q;
    jq_push_o    = 1'b0;

    jq_job_o.drain    = 1'b0;
    jq_job_o.pix      = {in_i.red_in, in_i.green_in, in_i.blue_in};
    jq_job_o.slot_wr  = slot_q;
    jq_job_o.slot_a   = slot_prev(slot_q);
    jq_job_o.slot_b   = slot_next(slot_q);
    jq_job_o.col      = col_q;
    jq_job_o.emit1    = (row_q != '0) && (col_q != '0);
    jq_job_o.emit2    = (row_q != '0) && (col_q == w_last);
    jq_job_o.interior = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
    jq_job_o.last     = 1'b0;

    if (restart_i) begin
      row_d       = '0;
      col_d       = '0;
      slot_d      = '0;
      draining_d  = 1'b0;
      drain_col_d = '0;
    end else if (accept) begin
      if (in_i.action) begin
        if (draining_q) begin
          jq_push_o         = 1'b1;
          jq_job_o.drain    = 1'b1;
          jq_job_o.slot_a   = drain_slot_q;
          jq_job_o.col      = drain_col_q;
          jq_job_o.emit1    = 1'b1;
          jq_job_o.emit2    = 1'b0;
          jq_job_o.interior = 1'b0;
          jq_job_o.last     = (drain_col_q == w_last);
          if (drain_col_q == w_last) begin
            draining_d  = 1'b0;
            drain_col_d = '0;
          end else begin
            drain_col_d = drain_col_q + COL_W'(1);
          end
        end
      end else if (!draining_q) begin
        jq_push_o = 1'b1;
        if (col_q == w_last) begin
          col_d = '0;
          if (row_q == h_last) begin
            row_d        = '0;
            slot_d       = '0;
            draining_d   = 1'b1;
            drain_col_d  = '0;
            drain_slot_d = slot_q;
          end else begin
            row_d  = row_q + ROW_W'(1);
            slot_d = slot_next(slot_q);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q        <= '0;
      col_q        <= '0;
      slot_q       <= '0;
      draining_q   <= 1'b0;
      drain_col_q  <= '0;
      drain_slot_q <= '0;
    end else begin
      row_q        <= row_d;
      col_q        <= col_d;
      slot_q       <= slot_d;
      draining_q   <= draining_d;
      drain_col_q  <= drain_col_d;
      drain_slot_q <= drain_slot_d;
    end
  end

endmodule

// ===== hdl/bbr_job_queue.sv =====
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
module bbr_job_queue
  import bbr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  bbr_job_t job_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output bbr_job_t job_o
);

  localparam int PTR_W = $clog2(JQ_DEPTH);
  localparam int CNT_W = $clog2(JQ_DEPTH + 1);

  bbr_job_t         slot_q [JQ_DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [PTR_W-1:0] rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(JQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = slot_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = do_push ? wp_q + PTR_W'(1) : wp_q;
    rp_d  = do_pop ? rp_q + PTR_W'(1) : rp_q;
    cnt_d = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/bbr_back.sv =====
// Back end: line store, 3x3 column window, divide by nine and the result buffer.
`timescale 1ns / 1ps
module bbr_back
  import bbr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     jq_valid_i,
  input  bbr_job_t jq_job_i,
  output logic     jq_pop_o,
  bbr_out_if.source out_o
);

  localparam int PROD_W = WSUM_W + RECIP_SH;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    logic drain;
    logic emit1;
    logic emit2;
    logic interior;
    logic last;
  } flags_t;

  // line store: three rows, one slot per row modulo three
  logic [PIX_W-1:0] store_mem [3 * MAX_WIDTH];

  logic adv;

  // stage 1: read data back from the store
  logic             s1_vld_q;
  bbr_job_t         s1_job_q;
  logic [PIX_W-1:0] rd_a_q;
  logic [PIX_W-1:0] rd_b_q;
  logic [2:0][CSUM_W-1:0] csum;

  // column window, index 0 holds the newest column
  logic [2:0][CSUM_W-1:0] cs_q [3];
  logic [PIX_W-1:0]       ctr_q [2];

  // stage 2: window sum
  logic             s2_vld_q;
  flags_t           s2_flags_q;
  logic [PIX_W-1:0] s2_drain_pix_q;
  logic [2:0][WSUM_W-1:0] wsum;
  logic [PIX_W-1:0] pa;

  // stage 3: multiply by reciprocal
  logic             s3_vld_q;
  flags_t           s3_flags_q;
  logic [2:0][WSUM_W-1:0] s3_sum_q;
  logic [PIX_W-1:0] s3_pa_q;
  logic [PIX_W-1:0] s3_pb_q;
  logic [2:0][PROD_W-1:0] prod;
  logic [2:0][CH_W-1:0]   quot;

  // stage 4: select and push results
  logic             s4_vld_q;
  flags_t           s4_flags_q;
  logic [PIX_W-1:0] s4_q_q;
  logic [PIX_W-1:0] s4_pa_q;
  logic [PIX_W-1:0] s4_pb_q;
  logic [PIX_W-1:0] res1_pix;
  bbr_res_t         res1;
  bbr_res_t         res2;
  logic             push1;
  logic             push2;

  // result buffer
  bbr_res_t            rq_q [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] rq_wp_q, rq_wp_d;
  logic [RQ_PTR_W-1:0] rq_rp_q, rq_rp_d;
  logic [RQ_CNT_W-1:0] rq_cnt_q, rq_cnt_d;
  logic                rq_pop;

  // advance the whole pipe only if the buffer can take two words
  assign adv      = (rq_cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign jq_pop_o = adv && jq_valid_i;

  always_ff @(posedge clk_i) begin
    if (jq_pop_o) begin
      if (!jq_job_i.drain) begin
        store_mem[store_addr(jq_job_i.slot_wr, jq_job_i.col)] <= jq_job_i.pix;
      end
      rd_a_q <= store_mem[store_addr(jq_job_i.slot_a, jq_job_i.col)];
      rd_b_q <= store_mem[store_addr(jq_job_i.slot_b, jq_job_i.col)];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      csum[k] = CSUM_W'(rd_b_q[k*CH_W +: CH_W]) + CSUM_W'(rd_a_q[k*CH_W +: CH_W])
              + CSUM_W'(s1_job_q.pix[k*CH_W +: CH_W]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wsum[k] = WSUM_W'(cs_q[0][k]) + WSUM_W'(cs_q[1][k]) + WSUM_W'(cs_q[2][k]);
    end
    pa = s2_flags_q.drain ? s2_drain_pix_q : ctr_q[1];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = PROD_W'(s3_sum_q[k]) * PROD_W'(RECIP9);
      quot[k] = prod[k][RECIP_SH +: CH_W];
    end
  end

  always_comb begin
    res1_pix   = s4_flags_q.interior ? s4_q_q : s4_pa_q;
    res1.red   = res1_pix[2*CH_W +: CH_W];
    res1.green = res1_pix[CH_W +: CH_W];
    res1.blue  = res1_pix[0 +: CH_W];
    res1.last  = s4_flags_q.last;
    res2.red   = s4_pb_q[2*CH_W +: CH_W];
    res2.green = s4_pb_q[CH_W +: CH_W];
    res2.blue  = s4_pb_q[0 +: CH_W];
    res2.last  = 1'b0;
    push1      = adv && s4_vld_q && s4_flags_q.emit1;
    push2      = adv && s4_vld_q && s4_flags_q.emit2;
  end

  // pipeline payload, held on stall
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_job_q <= jq_job_i;
      if (s1_vld_q && !s1_job_q.drain) begin
        cs_q[0]  <= csum;
        cs_q[1]  <= cs_q[0];
        cs_q[2]  <= cs_q[1];
        ctr_q[0] <= rd_a_q;
        ctr_q[1] <= ctr_q[0];
      end
      s2_flags_q     <= '{drain: s1_job_q.drain, emit1: s1_job_q.emit1,
                          emit2: s1_job_q.emit2, interior: s1_job_q.interior,
                          last: s1_job_q.last};
      s2_drain_pix_q <= rd_a_q;
      s3_flags_q     <= s2_flags_q;
      s3_sum_q       <= wsum;
      s3_pa_q        <= pa;
      s3_pb_q        <= ctr_q[0];
      s4_flags_q     <= s3_flags_q;
      s4_q_q         <= quot;
      s4_pa_q        <= s3_pa_q;
      s4_pb_q        <= s3_pb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= jq_pop_o;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // result buffer, up to two pushes and one pop per cycle
  assign rq_pop           = out_o.valid && out_o.ready;
  assign out_o.valid      = (rq_cnt_q != '0);
  assign out_o.red_out    = rq_q[rq_rp_q].red;
  assign out_o.green_out  = rq_q[rq_rp_q].green;
  assign out_o.blue_out   = rq_q[rq_rp_q].blue;
  assign out_o.frame_last = rq_q[rq_rp_q].last;

  always_comb begin
    rq_wp_d  = rq_wp_q + RQ_PTR_W'(push1) + RQ_PTR_W'(push2);
    rq_rp_d  = rq_pop ? rq_rp_q + RQ_PTR_W'(1) : rq_rp_q;
    rq_cnt_d = rq_cnt_q + RQ_CNT_W'(push1) + RQ_CNT_W'(push2) - RQ_CNT_W'(rq_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push1) begin
      rq_q[rq_wp_q] <= res1;
    end
    if (push2) begin
      rq_q[rq_wp_q + RQ_PTR_W'(1)] <= res2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wp_q  <= '0;
      rq_rp_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      rq_wp_q  <= rq_wp_d;
      rq_rp_q  <= rq_rp_d;
      rq_cnt_q <= rq_cnt_d;
    end
  end

endmodule

// ===== hdl/box_blur_3x3_rgb.sv =====
// Top level of the streaming 3x3 RGB box blur with its APB register block.
//
//   channel  dir  handshake           word
//   in_i     in   valid/ready         action, red_in, green_in, blue_in
//   out_o    out  valid/ready         red_out, green_out, blue_out, frame_last
//   apb      in   psel/penable/pready frame_width @0x0, frame_height @0x4
//
// Sustained rate is one word per cycle on both sides while out_o stays ready; the second word
// of a row's last pixel waits in the result buffer while the next row's first pixel gives none.
// An accepted word passes through the job queue, store read, column sum, window sum,
// divide-by-nine multiply and result buffer on its way to the output.
// Reset clears control state only; store words not written this frame never reach out_o.
// Stall the front only on a full job queue, the back as a whole on a short result buffer.
`timescale 1ns / 1ps
module box_blur_3x3_rgb
  import bbr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bbr_in_if.sink      in_i,
  bbr_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  logic             cfg_wr;
  bbr_reg_e         reg_sel;

  logic     jq_push;
  bbr_job_t jq_push_job;
  logic     jq_full;
  logic     jq_valid;
  logic     jq_pop;
  bbr_job_t jq_head;

  // registers are word aligned; bit 2 picks the register
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = bbr_reg_e'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(640);
      height_q <= CFG_W'(480);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default:    ;
      endcase
    end
  end

  // any register write restarts the frame in the front end
  bbr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_wr),
    .width_i   (width_q),
    .height_i  (height_q),
    .in_i      (in_i),
    .jq_full_i (jq_full),
    .jq_push_o (jq_push),
    .jq_job_o  (jq_push_job)
  );

  bbr_job_queue u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jq_push),
    .job_i   (jq_push_job),
    .full_o  (jq_full),
    .valid_o (jq_valid),
    .pop_i   (jq_pop),
    .job_o   (jq_head)
  );

  bbr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .jq_valid_i (jq_valid),
    .jq_job_i   (jq_head),
    .jq_pop_o   (jq_pop),
    .out_o      (out_o)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the streaming 3x3 RGB box blur.
`timescale 1ns / 1ps
module tb;
  import bbr_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 7;
  // Hold-off after the last expected word, so that words with no output leave the pipeline.
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 600_000;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_WORDS   = 125;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bbr_in_if  in_ch ();
  bbr_out_if out_ch ();

  box_blur_3x3_rgb dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Pacing of both sides, in percent of cycles.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Mirror of the block: register values, frame position and the three-row line store.
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      row_pos;
  int unsigned      col_pos;
  int unsigned      drain_pos;
  bit               draining;
  logic [PIX_W-1:0] line_mem [3][MAX_WIDTH];

  // Blurred words still owed by the block, oldest first.
  bbr_res_t    blur_q[$];
  bbr_res_t    head_word;
  int unsigned err_count;
  int unsigned useful_words;
  int unsigned cycle_cnt;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Run watchdog: a hung handshake must not stall the run forever.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver side: redraw ready at each falling edge, low for recv_stall_pct percent.
  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned lim);
    if (v < 3) return 3;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic int unsigned eff_width();
    return clamp_size(width_reg, MAX_WIDTH);
  endfunction

  function automatic int unsigned eff_height();
    return clamp_size(height_reg, MAX_HEIGHT);
  endfunction

  // Value of output pixel (r,c); border pixels pass straight through.
  function automatic logic [PIX_W-1:0] window_mean(int unsigned r, int unsigned c,
                                                   int unsigned w, int unsigned h);
    int unsigned      sum_r;
    int unsigned      sum_g;
    int unsigned      sum_b;
    logic [PIX_W-1:0] p;
    if (r == 0 || c == 0 || r + 1 >= h || c + 1 >= w)
      return line_mem[2'(r % 3)][COL_W'(c)];
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        p = line_mem[2'((r - 1 + dr) % 3)][COL_W'(c - 1 + dc)];
        sum_r += 32'(p[23:16]);
        sum_g += 32'(p[15:8]);
        sum_b += 32'(p[7:0]);
      end
    end
    return {CH_W'(sum_r / 9), CH_W'(sum_g / 9), CH_W'(sum_b / 9)};
  endfunction

  function automatic void owe_word(logic [PIX_W-1:0] pix, logic last);
    bbr_res_t e;
    e.red   = pix[23:16];
    e.green = pix[15:8];
    e.blue  = pix[7:0];
    e.last  = last;
    blur_q.push_back(e);
  endfunction

  // Advance the mirror by one accepted word and queue whatever it makes the block emit.
  function automatic void track_word(logic act, logic [PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    w = eff_width();
    h = eff_height();
    if (act) begin
      // drain tick outside a drain is dropped by the block
      if (!draining) return;
      useful_words++;
      owe_word(line_mem[2'((h - 1) % 3)][COL_W'(drain_pos)], drain_pos + 1 == w);
      drain_pos++;
      if (drain_pos >= w) begin
        drain_pos = 0;
        draining  = 1'b0;
      end
      return;
    end
    // a pixel that shows up during the drain is dropped too
    if (draining) return;
    useful_words++;
    line_mem[2'(row_pos % 3)][COL_W'(col_pos)] = pix;
    if (row_pos >= 1 && col_pos >= 1) begin
      owe_word(window_mean(row_pos - 1, col_pos - 1, w, h), 1'b0);
      // the row's last column flushes its own output pixel as a second word
      if (col_pos + 1 == w) owe_word(window_mean(row_pos - 1, col_pos, w, h), 1'b0);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos   = 0;
        drain_pos = 0;
        draining  = 1'b1;
      end
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Compare every accepted output word with the oldest owed word.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (blur_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word: rgb %02h %02h %02h last %0b",
                                out_ch.red_out, out_ch.green_out, out_ch.blue_out,
                                out_ch.frame_last));
      end else begin
        head_word = blur_q.pop_front();
        if (out_ch.red_out !== head_word.red || out_ch.green_out !== head_word.green ||
            out_ch.blue_out !== head_word.blue || out_ch.frame_last !== head_word.last) begin
          flag_mismatch($sformatf(
            "word mismatch: expected rgb %02h %02h %02h last %0b, got %02h %02h %02h last %0b",
            head_word.red, head_word.green, head_word.blue, head_word.last,
            out_ch.red_out, out_ch.green_out, out_ch.blue_out, out_ch.frame_last));
        end
      end
    end
  end

  // Offer one word, idling first at the sender's pace, and hold it until accepted.
  task automatic send_word(input logic act, input logic [PIX_W-1:0] pix);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    = 1'b1;
    in_ch.action   = act;
    in_ch.red_in   = pix[23:16];
    in_ch.green_in = pix[15:8];
    in_ch.blue_in  = pix[7:0];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    track_word(act, pix);
  endtask

  // Drop valid, collect every owed word, then let words with no output leave the pipe.
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (blur_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write only on an idle block; every write restarts the frame.
  task automatic write_reg(input bbr_reg_e idx, input logic [31:0] value);
    wait_drained();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 3'(idx) << 2;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_WIDTH) width_reg = value[CFG_W-1:0];
    else height_reg = value[CFG_W-1:0];
    row_pos   = 0;
    col_pos   = 0;
    drain_pos = 0;
    draining  = 1'b0;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_pace(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Mix of fully random, saturated, bright and dark pixels to work the rounding.
  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    p = PIX_W'($urandom);
    case ($urandom_range(3))
      0: ;
      1: begin
        for (int i = 0; i < 3; i++) p[i*CH_W +: CH_W] = p[i*CH_W] ? 8'hFF : 8'h00;
      end
      2: p = p | 24'hF8F8F8;
      default: p = p & 24'h070707;
    endcase
    return p;
  endfunction

  // Random junk in the upper bits of the register word; only the low bits count.
  function automatic logic [31:0] size_word(int unsigned lo, int unsigned hi);
    logic [31:0] v;
    v = $urandom;
    v[CFG_W-1:0] = CFG_W'($urandom_range(hi, lo));
    return v;
  endfunction

  // Pixels then drain ticks, with ignored words sprinkled in at noise_pct.
  task automatic send_frame(input int unsigned npix, input int unsigned ndrain,
                            input int unsigned noise_pct);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(99) < noise_pct) send_word(1'b1, rand_pixel());
      send_word(1'b0, rand_pixel());
    end
    for (int unsigned i = 0; i < ndrain; i++) begin
      if ($urandom_range(99) < noise_pct) send_word(1'b0, rand_pixel());
      send_word(1'b1, rand_pixel());
    end
  endtask

  // Under the reset size: stray drain ticks and a few top-row pixels give no words.
  task automatic test_ignored_words();
    set_pace(15, 15);
    repeat (3) send_word(1'b1, 24'hFFFFFF);
    send_word(1'b0, 24'h000000);
    send_word(1'b0, 24'hFFFFFF);
    send_word(1'b0, 24'hA5A5A5);
    send_word(1'b0, 24'h5A5A5A);
    send_word(1'b1, 24'h000000);
  endtask

  // Smallest frame with channel extremes, a pixel during the drain and a late tick.
  task automatic test_corner_frame();
    logic [PIX_W-1:0] pix [9];
    pix = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 24'hFFFFFF,
            24'h0000FF, 24'hFFFFFF, 24'hFFFFFF, 24'h80FF01};
    set_pace(15, 15);
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd3);
    foreach (pix[i]) send_word(1'b0, pix[i]);
    send_word(1'b0, 24'h123456);
    repeat (3) send_word(1'b1, 24'h000000);
    send_word(1'b1, 24'hFFFFFF);
    // all-white frame: every mean must stay at full scale
    for (int i = 0; i < 9; i++) send_word(1'b0, 24'hFFFFFF);
    repeat (3) send_word(1'b1, 24'h000000);
  endtask

  // A write mid-frame and one mid-drain must both start a fresh frame.
  task automatic test_restart_on_write();
    set_pace(15, 15);
    write_reg(REG_WIDTH, 32'd5);
    write_reg(REG_HEIGHT, 32'd4);
    send_frame(7, 0, 0);
    write_reg(REG_HEIGHT, 32'd4);
    send_frame(20, 2, 0);
    write_reg(REG_WIDTH, 32'd5);
    send_frame(20, 5, 0);
  endtask

  // Sizes below three are clamped; only the low eleven bits of a write count.
  task automatic test_size_clamping();
    set_pace(0, 0);
    write_reg(REG_WIDTH, 32'hFFFF_F800);
    write_reg(REG_HEIGHT, 32'd2);
    send_frame(9, 3, 0);
    write_reg(REG_WIDTH, 32'd1);
    write_reg(REG_HEIGHT, 32'hFFFF_F801);
    send_frame(9, 3, 0);
    write_reg(REG_WIDTH, 32'd2);
    write_reg(REG_HEIGHT, 32'd0);
    send_frame(9, 3, 0);
  endtask

  // Mostly whole small frames with random content; some cut short or half drained.
  task automatic test_random_frames();
    int unsigned pace_send [4];
    int unsigned pace_recv [4];
    int unsigned phase_base;
    int unsigned w;
    int unsigned h;
    int unsigned kind;
    pace_send = '{0, 72, 0, 15};
    pace_recv = '{0, 0, 72, 15};
    foreach (pace_send[ph]) begin
      set_pace(pace_send[ph], pace_recv[ph]);
      phase_base = useful_words;
      while (useful_words - phase_base < PHASE_WORDS) begin
        if ($urandom_range(3) == 0)
          write_reg(REG_WIDTH, ($urandom_range(7) == 0) ? size_word(0, 2) : size_word(3, 12));
        if ($urandom_range(3) == 0)
          write_reg(REG_HEIGHT, ($urandom_range(7) == 0) ? size_word(0, 2) : size_word(3, 8));
        w = eff_width();
        h = eff_height();
        kind = $urandom_range(19);
        if (kind == 0) begin
          send_frame($urandom_range(w * h - 1, 1), 0, 5);
          write_reg(REG_WIDTH, 32'(width_reg));
        end else if (kind == 1) begin
          send_frame(w * h, $urandom_range(w - 1, 0), 5);
          write_reg(REG_HEIGHT, 32'(height_reg));
        end else begin
          send_frame(w * h, w, 5);
        end
      end
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.action   = 1'b0;
    in_ch.red_in   = '0;
    in_ch.green_in = '0;
    in_ch.blue_in  = '0;
    out_ch.ready   = 1'b0;
    cycle_cnt      = 0;
    err_count      = 0;
    useful_words   = 0;
    width_reg      = CFG_W'(640);
    height_reg     = CFG_W'(480);
    row_pos        = 0;
    col_pos        = 0;
    drain_pos      = 0;
    draining       = 1'b0;
    set_pace(0, 0);
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_ignored_words();
    test_corner_frame();
    test_restart_on_write();
    test_size_clamping();
    test_random_frames();

    wait_drained();
    if (err_count == 0 && blur_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bbr_pkg.sv
hdl/bbr_stream_if.sv
hdl/bbr_front.sv
hdl/bbr_job_queue.sv
hdl/bbr_back.sv
hdl/box_blur_3x3_rgb.sv
sim/tb.sv
